[sv/dq_pkg.sv]
// shared types and constants for the double-ended queue unit
// no dependencies
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [WORD_W-1:0] data_word;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] popped_word;
    status_t           status;
    logic              is_empty;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

endpackage

[sv/dq_cell.sv]
// one storage cell of the queue row: holds one word, shifts to either neighbor
// depends on dq_pkg
module dq_cell
  import dq_pkg::*;
(
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [WORD_W-1:0] left,
  input  logic [WORD_W-1:0] right,
  input  logic [WORD_W-1:0] load,
  output logic [WORD_W-1:0] data
);

  logic [WORD_W-1:0] data_next;

  always_comb begin
    unique case (op)
      CELL_HOLD:       data_next = data;
      CELL_FROM_LEFT:  data_next = left;
      CELL_FROM_RIGHT: data_next = right;
      CELL_LOAD:       data_next = load;
      default:         data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[sv/double_ended_queue_unit.sv]
// top level of the double-ended queue unit: cell row, count and result register
// depends on dq_pkg and dq_cell
//
// Bounded double-ended queue of DEPTH 32-bit words held in a row of cells,
// front entry always in cell 0. Every word on req (push front, push back,
// pop front, pop back) gives exactly one word on rsp in the cycle after it
// is taken, with the popped word, status (underflow on empty, dropped push
// on full), empty flag and occupancy. One word is taken every cycle as long
// as the result register is free or drained in the same cycle; a push front
// or pop front moves the whole row by one cell, a pop back reads the last
// occupied cell.
module double_ended_queue_unit
  import dq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  cell_op_t          ops [DEPTH];
  logic [WORD_W-1:0] cells [DEPTH];
  logic [IDX_W-1:0]  back_idx;
  logic              accept;
  logic              full;
  logic              empty;
  logic              push_front;
  logic              push_back;
  logic              pop_front;
  rsp_t              rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign back_idx  = IDX_W'(count - CNT_W'(1));

  always_comb begin
    count_next           = count;
    push_front           = 1'b0;
    push_back            = 1'b0;
    pop_front            = 1'b0;
    rsp_next.popped_word = '0;
    rsp_next.status      = ST_OK;
    unique case (req.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          rsp_next.status = ST_OVERFLOW;
        end else begin
          push_front = (req.cmd == CMD_PUSH_FRONT);
          push_back  = (req.cmd == CMD_PUSH_BACK);
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          rsp_next.status = ST_UNDERFLOW;
        end else begin
          pop_front            = 1'b1;
          rsp_next.popped_word = cells[0];
          count_next           = count - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          rsp_next.status = ST_UNDERFLOW;
        end else begin
          rsp_next.popped_word = cells[back_idx];
          count_next           = count - CNT_W'(1);
        end
      end
      default: begin
        rsp_next.status = ST_OK;
      end
    endcase
    rsp_next.is_empty  = (count_next == '0);
    rsp_next.occupancy = OCC_W'(count_next);
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ops[i] = CELL_HOLD;
      if (accept) begin
        if (push_front) begin
          ops[i] = CELL_FROM_LEFT;
        end else if (pop_front) begin
          ops[i] = CELL_FROM_RIGHT;
        end else if (push_back && (CNT_W'(i) == count)) begin
          ops[i] = CELL_LOAD;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
    if (g == 0) begin : g_first
      assign left = req.data_word;
    end else begin : g_mid_l
      assign left = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cells[g+1];
    end
    dq_cell u_cell (
      .clk   (clk),
      .op    (ops[g]),
      .left  (left),
      .right (right),
      .load  (req.data_word),
      .data  (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

[sim/tb.sv]
// self-checking testbench for double_ended_queue_unit: a class mirrors the deque ring and
// checks every rsp word field by field, with idle and stall on both channels
// depends on dq_pkg and the unit's rtl
module tb;
  import dq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 1426;
  localparam int IDLE_PCT = 28;
  localparam int PRINT_CAP = 40;

  class deque_mirror;
    logic [WORD_W-1:0] ring [DEPTH];
    int head = 0;
    int tail = 0;
    int held = 0;
    rsp_t pending_rsp [$];
    int errors = 0;
    int n_checked = 0;
    int n_push = 0;
    int n_pop = 0;
    int n_empty_pop = 0;
    int n_full_push = 0;
    int peak = 0;

    function void take_cmd(req_t w);
      rsp_t want;
      want = '0;
      want.status = ST_OK;
      case (w.cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (held >= DEPTH) begin
            want.status = ST_OVERFLOW;
            n_full_push++;
          end else if (w.cmd == CMD_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = w.data_word;
            held++;
            n_push++;
          end else begin
            ring[tail] = w.data_word;
            tail = (tail + 1) % DEPTH;
            held++;
            n_push++;
          end
        end
        default: begin
          if (held == 0) begin
            want.status = ST_UNDERFLOW;
            n_empty_pop++;
          end else if (w.cmd == CMD_POP_FRONT) begin
            want.popped_word = ring[head];
            head = (head + 1) % DEPTH;
            held--;
            n_pop++;
          end else begin
            tail = (tail + DEPTH - 1) % DEPTH;
            want.popped_word = ring[tail];
            held--;
            n_pop++;
          end
        end
      endcase
      if (held > peak) peak = held;
      want.is_empty = (held == 0);
      want.occupancy = OCC_W'(held);
      pending_rsp.push_back(want);
    endfunction

    task flag_mismatch(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch on result %0d: %s", n_checked, what);
    endtask

    task match_result(rsp_t got);
      rsp_t want;
      n_checked++;
      if (pending_rsp.size() == 0) begin
        flag_mismatch("rsp word with nothing outstanding");
        return;
      end
      want = pending_rsp.pop_front();
      if (got.popped_word !== want.popped_word)
        flag_mismatch($sformatf("popped_word %h, want %h", got.popped_word, want.popped_word));
      if (got.status !== want.status)
        flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.is_empty !== want.is_empty)
        flag_mismatch($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
      if (got.occupancy !== want.occupancy)
        flag_mismatch($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
    endtask

    function int outstanding();
      return pending_rsp.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  bit steady = 1'b0;
  int cycles = 0;
  deque_mirror mirror = new();

  double_ended_queue_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) mirror.take_cmd(req);
      if (rsp_valid && !rsp_stall) mirror.match_result(rsp);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic req_t mk_word(cmd_t c, logic [WORD_W-1:0] d);
    req_t w;
    w.cmd = c;
    w.data_word = d;
    return w;
  endfunction

  task automatic send_word(input req_t w);
    while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic run_directed();
    send_word(mk_word(CMD_POP_FRONT, '0));
    send_word(mk_word(CMD_POP_BACK, '1));
    // front pointer wraps below zero on the first push
    send_word(mk_word(CMD_PUSH_FRONT, '1));
    send_word(mk_word(CMD_PUSH_BACK, '0));
    send_word(mk_word(CMD_POP_FRONT, '0));
    send_word(mk_word(CMD_POP_BACK, '0));
    for (int i = 0; i < DEPTH; i++) begin
      send_word(mk_word(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                        (i[0] ? 32'hAAAA_AAAA : 32'h5555_5555) ^ (32'h1 << (2 * i))));
    end
    // both pushes on a full queue get dropped
    send_word(mk_word(CMD_PUSH_FRONT, 32'hDEAD_BEEF));
    send_word(mk_word(CMD_PUSH_BACK, 32'h8000_0001));
  endtask

  task automatic run_random(input int count);
    int done;
    int seg;
    int push_pct;
    logic [WORD_W-1:0] d;
    cmd_t c;
    done = 0;
    while (done < count) begin
      seg = $urandom_range(8, 48);
      case ($urandom_range(4))
        0: push_pct = 92;
        1: push_pct = 70;
        2: push_pct = 50;
        3: push_pct = 30;
        default: push_pct = 8;
      endcase
      for (int k = 0; k < seg && done < count; k++) begin
        if ($urandom_range(99) < push_pct)
          c = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else
          c = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
        case ($urandom_range(7))
          0: d = '0;
          1: d = '1;
          2: d = 32'h1 << $urandom_range(WORD_W - 1);
          default: d = $urandom();
        endcase
        steady = (done >= 550 && done < 850);
        send_word(mk_word(c, d));
        done++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(RANDOM_WORDS);
    req_valid <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("checked %0d rsp words: %0d pushes kept, %0d pops, peak occupancy %0d",
             mirror.n_checked, mirror.n_push, mirror.n_pop, mirror.peak);
    $display("pops on empty queue %0d, pushes dropped on full queue %0d, mismatches %0d",
             mirror.n_empty_pop, mirror.n_full_push, mirror.errors);
    if (mirror.errors == 0 && mirror.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
